// ===== design/task_scheduler_semaphore_engine_macros.svh =====
// Assertion macros for the task scheduler semaphore engine.
`ifndef TASK_SCHEDULER_SEMAPHORE_ENGINE_MACROS_SVH
`define TASK_SCHEDULER_SEMAPHORE_ENGINE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Plain invariant checked on every clock edge.
`define TSE_ASSERT_ALWAYS(label, clk, cond) \
  label: assert property (@(posedge clk) (cond)) else $error("assertion failed");
`endif

// ===== design/tse_pkg.sv =====
// Shared types and constants for the task scheduler semaphore engine.
package tse_pkg;
  localparam int TASK_COUNT_DEF = 32;
  localparam int SEM_COUNT_DEF  = 16;
  localparam int CPU_COUNT_DEF  = 8;
  localparam int COUNT_MAX_DEF  = 255;

  localparam logic [2:0] OP_CREATE   = 3'd0;
  localparam logic [2:0] OP_TEARDOWN = 3'd1;
  localparam logic [2:0] OP_SCHEDULE = 3'd2;
  localparam logic [2:0] OP_TRAP     = 3'd3;
  localparam logic [2:0] OP_SEMINIT  = 3'd4;
  localparam logic [2:0] OP_SEMWAIT  = 3'd5;
  localparam logic [2:0] OP_SEMSIG   = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_IDLE    = 2'd2;
  localparam logic [1:0] ST_ERROR   = 2'd3;

  localparam logic [2:0] TS_FREE     = 3'd0;
  localparam logic [2:0] TS_RUNNABLE = 3'd1;
  localparam logic [2:0] TS_RUNNING  = 3'd2;
  localparam logic [2:0] TS_WAITING  = 3'd3;
  localparam logic [2:0] TS_DEAD     = 3'd4;

  // controller -> datapath commands
  typedef struct packed {
    logic load;    // capture input word
    logic exec;    // perform the operation
    logic finish;  // emit result
  } tse_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic done;
  } tse_stat_t;
endpackage

// ===== design/task_scheduler_semaphore_engine.sv =====
// Top level of the task scheduler semaphore engine.
//  channel | ports                                   | handshake
//  input   | in_opcode in_cpu in_task_id in_sem_id    | start & !busy
//          | in_init_value                           |
//  result  | out_status out_task_valid out_task_out  | out_valid strobe, 1 cycle
// The result strobe rises after a word is accepted and has passed load, two execute steps
// over the link tables (the schedule pop and signal requeue need the second) and result.
// busy stays high until the strobe cycle ends, so a new word waits for the last result.
// Synchronous active-low reset clears task states, counts and valid bits at once.
// The result cannot be stalled.
`include "task_scheduler_semaphore_engine_macros.svh"
module task_scheduler_semaphore_engine #(
  parameter int TASK_COUNT = tse_pkg::TASK_COUNT_DEF,
  parameter int SEM_COUNT  = tse_pkg::SEM_COUNT_DEF,
  parameter int CPU_COUNT  = tse_pkg::CPU_COUNT_DEF,
  parameter int COUNT_MAX  = tse_pkg::COUNT_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_opcode,
  input  logic [2:0] in_cpu,
  input  logic [4:0] in_task_id,
  input  logic [3:0] in_sem_id,
  input  logic [7:0] in_init_value,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic       out_task_valid,
  output logic [4:0] out_task_out
);
  tse_pkg::tse_cmd_t  cmd;
  tse_pkg::tse_stat_t stat;
  logic ctl_busy;
  logic ctl_start;

  // no new word while the previous result is on the ports
  assign ctl_start = start & ~out_valid;

  tse_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(ctl_start), .busy(ctl_busy), .cmd(cmd), .stat(stat)
  );

  tse_dp #(
    .TASK_COUNT(TASK_COUNT), .SEM_COUNT(SEM_COUNT),
    .CPU_COUNT(CPU_COUNT), .COUNT_MAX(COUNT_MAX)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_opcode(in_opcode), .in_cpu(in_cpu), .in_task_id(in_task_id),
    .in_sem_id(in_sem_id), .in_init_value(in_init_value),
    .out_valid(out_valid), .out_status(out_status),
    .out_task_valid(out_task_valid), .out_task_out(out_task_out)
  );

  // hold busy through the strobe cycle
  assign busy = ctl_busy | out_valid;

  `TSE_ASSERT_IMP(a_idle_status, clk, rst_n, out_valid && out_status == tse_pkg::ST_IDLE, !out_task_valid)
  `TSE_ASSERT_IMP(a_block_status, clk, rst_n, out_valid && out_status == tse_pkg::ST_BLOCKED, !out_task_valid)
  `TSE_ASSERT_IMP(a_one_strobe, clk, rst_n, out_valid, !$past(out_valid))
endmodule

// ===== design/tse_ctrl.sv =====
// Controller state machine sequencing load, execute and result.
module tse_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output tse_pkg::tse_cmd_t  cmd,
  input  tse_pkg::tse_stat_t stat
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_EXEC = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_EXEC;
      S_EXEC: if (stat.done) state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && start;
  assign cmd.exec   = (state_r == S_EXEC);
  assign cmd.finish = (state_r == S_DONE);
endmodule

// ===== design/tse_dp.sv =====
// Datapath: task tables, queue links, semaphore counts and CPU slots.
module tse_dp #(
  parameter int TASK_COUNT = tse_pkg::TASK_COUNT_DEF,
  parameter int SEM_COUNT  = tse_pkg::SEM_COUNT_DEF,
  parameter int CPU_COUNT  = tse_pkg::CPU_COUNT_DEF,
  parameter int COUNT_MAX  = tse_pkg::COUNT_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tse_pkg::tse_cmd_t  cmd,
  output tse_pkg::tse_stat_t stat,
  input  logic [2:0]         in_opcode,
  input  logic [2:0]         in_cpu,
  input  logic [4:0]         in_task_id,
  input  logic [3:0]         in_sem_id,
  input  logic [7:0]         in_init_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic               out_task_valid,
  output logic [4:0]         out_task_out
);
  localparam int TW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int QN = SEM_COUNT + 1;
  localparam int QW = $clog2(QN + 1);
  localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int SW = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
  localparam int NW = $clog2(COUNT_MAX + 1) + 1;
  localparam logic [QW-1:0] RUNQ = QW'(SEM_COUNT);
  localparam logic signed [NW-1:0] CMAX = NW'(COUNT_MAX);
  localparam logic signed [NW-1:0] CMIN = -CMAX - NW'(1);

  // task state, small enough for flip-flops with reset
  logic [2:0]    tstate_r [TASK_COUNT];
  logic [TW-1:0] nxt_r    [TASK_COUNT];
  logic [TW-1:0] prv_r    [TASK_COUNT];
  logic [TW-1:0] qfirst_r [QN];
  logic [TW-1:0] qlast_r  [QN];
  logic [QN-1:0] qne_r;
  logic signed [NW-1:0] cnt_r [SEM_COUNT];
  logic [TW-1:0] run_r    [CPU_COUNT];
  logic [CPU_COUNT-1:0] rv_r;

  logic [2:0] op_r;
  logic [7:0] cpu_r, tid_r, sid_r;
  logic [7:0] iv_r;
  // micro-step within exec: 0 first half, 1 second half
  logic       step_r;

  logic [1:0]    st_r;
  logic          tv_r;
  logic [TW-1:0] to_r;
  logic          ov_r;

  // decoded indices
  logic cpu_ok, tid_ok, sid_ok;
  logic [CW-1:0] c;
  logic [TW-1:0] t;
  logic [SW-1:0] s;
  assign cpu_ok = 32'(cpu_r) < CPU_COUNT;
  assign tid_ok = 32'(tid_r) < TASK_COUNT;
  assign sid_ok = 32'(sid_r) < SEM_COUNT;
  assign c = CW'(cpu_r);
  assign t = TW'(tid_r);
  assign s = SW'(sid_r);

  assign stat.done = step_r;

  // running task of the selected CPU
  logic [TW-1:0] rt;
  assign rt = run_r[c];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_COUNT; i++) tstate_r[i] <= tse_pkg::TS_FREE;
      for (int i = 0; i < SEM_COUNT; i++) cnt_r[i] <= '0;
      qne_r  <= '0;
      rv_r   <= '0;
      step_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      ov_r <= cmd.finish;
      if (cmd.load) begin
        op_r   <= in_opcode;
        cpu_r  <= 8'(in_cpu);
        tid_r  <= 8'(in_task_id);
        sid_r  <= 8'(in_sem_id);
        iv_r   <= in_init_value;
        step_r <= 1'b0;
        st_r   <= tse_pkg::ST_ERROR;
        tv_r   <= 1'b0;
        to_r   <= '0;
      end else if (cmd.exec && !step_r) begin
        // step 0: everything except the schedule pop and the signal requeue
        step_r <= 1'b1;
        case (op_r)
          tse_pkg::OP_CREATE: begin
            if (tid_ok && (tstate_r[t] == tse_pkg::TS_FREE ||
                           tstate_r[t] == tse_pkg::TS_DEAD)) begin
              tstate_r[t] <= tse_pkg::TS_RUNNABLE;
              if (!qne_r[RUNQ]) begin
                qfirst_r[RUNQ] <= t;
                qne_r[RUNQ] <= 1'b1;
              end else begin
                nxt_r[qlast_r[RUNQ]] <= t;
                prv_r[t] <= qlast_r[RUNQ];
              end
              qlast_r[RUNQ] <= t;
              st_r <= tse_pkg::ST_OK;
            end
          end
          tse_pkg::OP_TEARDOWN: begin
            if (tid_ok && tstate_r[t] == tse_pkg::TS_RUNNABLE) begin
              if (qfirst_r[RUNQ] == t && qlast_r[RUNQ] == t) qne_r[RUNQ] <= 1'b0;
              else if (qfirst_r[RUNQ] == t) qfirst_r[RUNQ] <= nxt_r[t];
              else if (qlast_r[RUNQ] == t) qlast_r[RUNQ] <= prv_r[t];
              else begin
                nxt_r[prv_r[t]] <= nxt_r[t];
                prv_r[nxt_r[t]] <= prv_r[t];
              end
              tstate_r[t] <= tse_pkg::TS_DEAD;
              st_r <= tse_pkg::ST_OK;
            end else if (tid_ok && tstate_r[t] == tse_pkg::TS_RUNNING) begin
              for (int i = 0; i < CPU_COUNT; i++)
                if (rv_r[i] && run_r[i] == t) rv_r[i] <= 1'b0;
              tstate_r[t] <= tse_pkg::TS_DEAD;
              st_r <= tse_pkg::ST_OK;
            end
          end
          tse_pkg::OP_SCHEDULE: begin
            // requeue the running task; pop happens in step 1
            if (cpu_ok && rv_r[c]) begin
              if (tstate_r[rt] == tse_pkg::TS_RUNNING) begin
                tstate_r[rt] <= tse_pkg::TS_RUNNABLE;
                if (!qne_r[RUNQ]) begin
                  qfirst_r[RUNQ] <= rt;
                  qne_r[RUNQ] <= 1'b1;
                end else begin
                  nxt_r[qlast_r[RUNQ]] <= rt;
                  prv_r[rt] <= qlast_r[RUNQ];
                end
                qlast_r[RUNQ] <= rt;
              end
              rv_r[c] <= 1'b0;
            end
          end
          tse_pkg::OP_TRAP: begin
            if (cpu_ok && rv_r[c]) begin
              st_r <= tse_pkg::ST_OK;
              tv_r <= 1'b1;
              to_r <= rt;
            end
          end
          tse_pkg::OP_SEMINIT: begin
            if (sid_ok && !qne_r[QW'(s)]) begin
              cnt_r[s] <= (32'(iv_r) > COUNT_MAX) ? CMAX : NW'(iv_r);
              st_r <= tse_pkg::ST_OK;
            end
          end
          tse_pkg::OP_SEMWAIT: begin
            if (sid_ok && cpu_ok) begin
              if (cnt_r[s] <= 0) begin
                if (rv_r[c] && tstate_r[rt] == tse_pkg::TS_RUNNING) begin
                  tstate_r[rt] <= tse_pkg::TS_WAITING;
                  if (!qne_r[QW'(s)]) begin
                    qfirst_r[QW'(s)] <= rt;
                    qne_r[QW'(s)] <= 1'b1;
                  end else begin
                    nxt_r[qlast_r[QW'(s)]] <= rt;
                    prv_r[rt] <= qlast_r[QW'(s)];
                  end
                  qlast_r[QW'(s)] <= rt;
                  rv_r[c] <= 1'b0;
                  st_r <= tse_pkg::ST_BLOCKED;
                  if (cnt_r[s] != CMIN) cnt_r[s] <= cnt_r[s] - NW'(1);
                end
              end else begin
                st_r <= tse_pkg::ST_OK;
                cnt_r[s] <= cnt_r[s] - NW'(1);
              end
            end
          end
          tse_pkg::OP_SEMSIG: begin
            // pop waiter here; append to run queue in step 1
            if (sid_ok) begin
              if (qne_r[QW'(s)]) begin
                to_r <= qfirst_r[QW'(s)];
                tv_r <= 1'b1;
                if (qlast_r[QW'(s)] == qfirst_r[QW'(s)]) qne_r[QW'(s)] <= 1'b0;
                else qfirst_r[QW'(s)] <= nxt_r[qfirst_r[QW'(s)]];
              end
              if (cnt_r[s] < CMAX) cnt_r[s] <= cnt_r[s] + NW'(1);
              st_r <= tse_pkg::ST_OK;
            end
          end
          default: ;
        endcase
      end else if (cmd.exec && step_r) begin
        step_r <= 1'b0;
        if (op_r == tse_pkg::OP_SCHEDULE && cpu_ok) begin
          if (!qne_r[RUNQ]) st_r <= tse_pkg::ST_IDLE;
          else begin
            if (qlast_r[RUNQ] == qfirst_r[RUNQ]) qne_r[RUNQ] <= 1'b0;
            else qfirst_r[RUNQ] <= nxt_r[qfirst_r[RUNQ]];
            tstate_r[qfirst_r[RUNQ]] <= tse_pkg::TS_RUNNING;
            run_r[c] <= qfirst_r[RUNQ];
            rv_r[c]  <= 1'b1;
            st_r <= tse_pkg::ST_OK;
            tv_r <= 1'b1;
            to_r <= qfirst_r[RUNQ];
          end
        end else if (op_r == tse_pkg::OP_SEMSIG && tv_r) begin
          tstate_r[to_r] <= tse_pkg::TS_RUNNABLE;
          if (!qne_r[RUNQ]) begin
            qfirst_r[RUNQ] <= to_r;
            qne_r[RUNQ] <= 1'b1;
          end else begin
            nxt_r[qlast_r[RUNQ]] <= to_r;
            prv_r[to_r] <= qlast_r[RUNQ];
          end
          qlast_r[RUNQ] <= to_r;
        end
      end
    end
  end

  assign out_valid      = ov_r;
  assign out_status     = st_r;
  assign out_task_valid = tv_r;
  assign out_task_out   = 5'(to_r);
endmodule
